[rtl/occ_pkg.sv]
// Shared types and constants for the occupancy counter with lamp control.
package occ_pkg;

    localparam int TOD_W  = 17;
    localparam int TICK_W = 8;
    localparam int LVL_W  = 7;
    localparam int LAMP_W = 3;
    localparam int PEND_W = 2;
    localparam int OP_W   = 2;
    localparam int IDX_W  = 3;
    localparam int WDATA_W = 17;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_BEAM_A = 2'd1,
        OP_BEAM_B = 2'd2,
        OP_EVAL   = 2'd3
    } op_t;

    typedef enum logic [IDX_W-1:0] {
        REG_WINDOW_START = 3'd0,
        REG_WINDOW_END   = 3'd1,
        REG_TIMEOUT      = 3'd2,
        REG_LEVEL_ONE    = 3'd3,
        REG_LEVEL_TWO    = 3'd4,
        REG_LEVEL_THREE  = 3'd5,
        REG_MAX_OCC      = 3'd6
    } reg_idx_t;

    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_A    = 2'd1;
    localparam logic [PEND_W-1:0] PEND_B    = 2'd2;

    localparam logic [LAMP_W-1:0] LAMPS_0 = 3'd0;
    localparam logic [LAMP_W-1:0] LAMPS_1 = 3'd1;
    localparam logic [LAMP_W-1:0] LAMPS_2 = 3'd2;
    localparam logic [LAMP_W-1:0] LAMPS_3 = 3'd3;
    localparam logic [LAMP_W-1:0] LAMPS_4 = 3'd4;

    localparam logic [TOD_W-1:0]  RST_WINDOW_START = 17'd64800;
    localparam logic [TOD_W-1:0]  RST_WINDOW_END   = 17'd79200;
    localparam logic [TICK_W-1:0] RST_TIMEOUT      = 8'd60;
    localparam logic [LVL_W-1:0]  RST_LEVEL_ONE    = 7'd10;
    localparam logic [LVL_W-1:0]  RST_LEVEL_TWO    = 7'd20;
    localparam logic [LVL_W-1:0]  RST_LEVEL_THREE  = 7'd30;
    localparam logic [LVL_W-1:0]  RST_MAX_OCC      = 7'd99;

    typedef struct packed {
        logic [TOD_W-1:0]  window_start;
        logic [TOD_W-1:0]  window_end;
        logic [TICK_W-1:0] timeout;
        logic [LVL_W-1:0]  level_one;
        logic [LVL_W-1:0]  level_two;
        logic [LVL_W-1:0]  level_three;
        logic [LVL_W-1:0]  max_occ;
    } cfg_t;

    typedef struct packed {
        logic [PEND_W-1:0] pending;
        logic [LVL_W-1:0]  occupancy;
        logic [LAMP_W-1:0] lamps_on;
    } res_t;

endpackage

[rtl/occupancy_counter_lamp_control.sv]
// Top level of the occupancy counter with lamp control.
//
// The block counts people through a doorway from two beam sensors and sets
// how many lamps are lit. Each input item on the s_ stream is one of four
// operations, chosen by s_tuser: a timer tick, a beam A event, a beam
// B event, or a lamp evaluation that uses time_of_day and dark from s_tdata.
// Every input item yields exactly one result item on the m_ stream carrying
// the lamp count, the people count and the pending-beam code after the item.
//
// An item passes through an input register and then the state update, whose
// outcome is captured in the output register, which drives m_tvalid. One
// item per cycle is sustained while the receiver keeps m_tready high. The
// state update is combinational: a saturating add, compares and threshold
// tests.
//
// When the receiver holds m_tready low, the output register keeps its item,
// the input register keeps the next one, and s_tready drops once both are full;
// nothing is lost or repeated. Reset clears the count, pending flags, tick
// counter and lamp level, empties both registers, and loads the configuration
// registers with their defaults. The user must write configuration through cfg_we/
// cfg_index/cfg_wdata only while no item is in flight, not enforced by the block.
module occupancy_counter_lamp_control #(
    parameter int COUNT_WIDTH = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // time_of_day[16:0], dark[17], zero
    input  logic [occ_pkg::OP_W-1:0]      s_tuser,   // op[1:0]
    // Result stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // lamps_on[2:0], occupancy[9:3],
                                                     // pending[11:10], zero
    // Configuration write port.
    input  logic                          cfg_we,
    input  logic [occ_pkg::IDX_W-1:0]     cfg_index,
    input  logic [occ_pkg::WDATA_W-1:0]   cfg_wdata
);
    import occ_pkg::*;

    cfg_t              cfg;
    res_t              result;

    logic              in_valid_reg, in_valid_next;
    logic [OP_W-1:0]   op_reg;
    logic [TOD_W-1:0]  tod_reg;
    logic              dark_reg;
    logic              out_valid_reg, out_valid_next;
    res_t              out_res_reg;

    logic              advance;
    logic              fire;
    logic              load;

    // The output register can take a new result when empty or being drained.
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign load     = s_tvalid && s_tready;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    occ_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    occ_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .op          (op_reg),
        .time_of_day (tod_reg),
        .dark        (dark_reg),
        .cfg         (cfg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg   <= s_tuser;
            tod_reg  <= s_tdata[TOD_W-1:0];
            dark_reg <= s_tdata[TOD_W];
        end
        if (fire)
        begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_res_reg};

endmodule

[rtl/occ_cfg.sv]
// Configuration register file for the occupancy counter.
module occ_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [occ_pkg::IDX_W-1:0]     cfg_index,
    input  logic [occ_pkg::WDATA_W-1:0]   cfg_wdata,
    output occ_pkg::cfg_t                 cfg
);
    import occ_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_WINDOW_START: cfg_next.window_start = cfg_wdata[TOD_W-1:0];
                REG_WINDOW_END:   cfg_next.window_end   = cfg_wdata[TOD_W-1:0];
                REG_TIMEOUT:      cfg_next.timeout      = cfg_wdata[TICK_W-1:0];
                REG_LEVEL_ONE:    cfg_next.level_one    = cfg_wdata[LVL_W-1:0];
                REG_LEVEL_TWO:    cfg_next.level_two    = cfg_wdata[LVL_W-1:0];
                REG_LEVEL_THREE:  cfg_next.level_three  = cfg_wdata[LVL_W-1:0];
                REG_MAX_OCC:      cfg_next.max_occ      = cfg_wdata[LVL_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_start <= RST_WINDOW_START;
            cfg_reg.window_end   <= RST_WINDOW_END;
            cfg_reg.timeout      <= RST_TIMEOUT;
            cfg_reg.level_one    <= RST_LEVEL_ONE;
            cfg_reg.level_two    <= RST_LEVEL_TWO;
            cfg_reg.level_three  <= RST_LEVEL_THREE;
            cfg_reg.max_occ      <= RST_MAX_OCC;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/occ_step.sv]
// Occupancy state and the per-item update of count, pending flags and lamp level.
module occ_step #(
    parameter int COUNT_WIDTH = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic [occ_pkg::OP_W-1:0]    op,
    input  logic [occ_pkg::TOD_W-1:0]   time_of_day,
    input  logic                        dark,
    input  occ_pkg::cfg_t               cfg,
    output occ_pkg::res_t               result
);
    import occ_pkg::*;

    // Common compare width: covers both the count and the 7-bit registers,
    // with one spare bit so that count + 1 cannot wrap.
    localparam int EW = ((COUNT_WIDTH > LVL_W) ? COUNT_WIDTH : LVL_W) + 1;

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   a_pend_reg, a_pend_next;
    logic                   b_pend_reg, b_pend_next;
    logic [TICK_W-1:0]      ticks_reg, ticks_next;
    logic [LAMP_W-1:0]      lamp_reg, lamp_next;

    logic [EW-1:0]          cnt_ext;
    logic [EW-1:0]          inc_val;
    logic [EW-1:0]          max_ext;
    logic [EW-1:0]          l1_ext, l2_ext, l3_ext;
    logic [EW-1:0]          occ_ext;
    logic [TICK_W-1:0]      ticks_inc;
    logic                   in_window;
    logic [LAMP_W-1:0]      level;

    assign cnt_ext   = EW'(count_reg);
    assign max_ext   = EW'(cfg.max_occ);
    assign l1_ext    = EW'(cfg.level_one);
    assign l2_ext    = EW'(cfg.level_two);
    assign l3_ext    = EW'(cfg.level_three);
    assign inc_val   = (cnt_ext + EW'(1) >= max_ext) ? max_ext : cnt_ext + EW'(1);
    assign ticks_inc = ticks_reg + TICK_W'(1);
    assign in_window = (time_of_day >= cfg.window_start) &&
                       (time_of_day <= cfg.window_end) && dark;

    // Threshold tests in fixed order; the last one that holds wins.
    always_comb
    begin
        level = lamp_reg;
        if (cnt_ext == '0)
            level = LAMPS_0;
        if (cnt_ext != '0 && cnt_ext < l1_ext)
            level = LAMPS_1;
        if (cnt_ext >= l1_ext && cnt_ext < l2_ext)
            level = LAMPS_2;
        if (cnt_ext >= l2_ext && cnt_ext < l3_ext)
            level = LAMPS_3;
        if (cnt_ext >= l3_ext)
            level = LAMPS_4;
    end

    always_comb
    begin
        count_next  = count_reg;
        a_pend_next = a_pend_reg;
        b_pend_next = b_pend_reg;
        ticks_next  = ticks_reg;
        lamp_next   = lamp_reg;
        case (op_t'(op))
            OP_TICK:
            begin
                if (a_pend_reg || b_pend_reg)
                begin
                    if (ticks_inc >= cfg.timeout)
                    begin
                        a_pend_next = 1'b0;
                        b_pend_next = 1'b0;
                        ticks_next  = '0;
                    end
                    else
                    begin
                        ticks_next = ticks_inc;
                    end
                end
            end
            OP_BEAM_A:
            begin
                if (b_pend_reg)
                begin
                    count_next  = inc_val[COUNT_WIDTH-1:0];
                    a_pend_next = 1'b0;
                    b_pend_next = 1'b0;
                    ticks_next  = '0;
                end
                else
                begin
                    a_pend_next = 1'b1;
                end
            end
            OP_BEAM_B:
            begin
                if (a_pend_reg)
                begin
                    if (count_reg != '0)
                        count_next = count_reg - COUNT_WIDTH'(1);
                    a_pend_next = 1'b0;
                    b_pend_next = 1'b0;
                    ticks_next  = '0;
                end
                else
                begin
                    b_pend_next = 1'b1;
                end
            end
            OP_EVAL:
            begin
                lamp_next = in_window ? level : LAMPS_0;
            end
            default:
            begin
                lamp_next = lamp_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            a_pend_reg <= 1'b0;
            b_pend_reg <= 1'b0;
            ticks_reg  <= '0;
            lamp_reg   <= '0;
        end
        else if (fire)
        begin
            count_reg  <= count_next;
            a_pend_reg <= a_pend_next;
            b_pend_reg <= b_pend_next;
            ticks_reg  <= ticks_next;
            lamp_reg   <= lamp_next;
        end
    end

    assign occ_ext          = EW'(count_next);
    assign result.lamps_on  = lamp_next;
    assign result.occupancy = occ_ext[LVL_W-1:0];
    assign result.pending   = a_pend_next ? PEND_A : (b_pend_next ? PEND_B : PEND_NONE);

endmodule

[sim/tb_occupancy_counter_lamp_control.sv]
// Self-checking testbench for the occupancy counter with lamp control.
`timescale 1ns / 100ps

module tb_occupancy_counter_lamp_control;

    import occ_pkg::*;

    // The run is ended as a failure if it has not finished by this many cycles.
    localparam int CYCLE_LIMIT = 200000;
    // Only the first mismatches are printed; all of them are counted.
    localparam int PRINT_LIMIT = 40;
    // Cycles of quiet after the last result.
    localparam int SETTLE_CYCLES = 8;
    // Every this many accepted results the receiver holds off for a long stretch.
    localparam int HOLD_PERIOD = 700;
    localparam int HOLD_CYCLES = 64;

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports.
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;          // time_of_day[16:0], dark[17], zero
    logic [1:0]  s_tuser = OP_TICK;     // op[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;               // lamps_on[2:0], occupancy[9:3], pending[11:10], zero
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_WINDOW_START;
    logic [16:0] cfg_wdata = '0;

    always #2 clk = ~clk;

    occupancy_counter_lamp_control #(
        .COUNT_WIDTH (7)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predicted room state. This is a private copy of what the block should
    // hold: the registers, the people count, the two beam flags with their
    // tick counter, and the lamp level left by the last evaluation.
    // ------------------------------------------------------------------
    cfg_t room_cfg = '{RST_WINDOW_START, RST_WINDOW_END, RST_TIMEOUT, RST_LEVEL_ONE,
                       RST_LEVEL_TWO, RST_LEVEL_THREE, RST_MAX_OCC};
    logic [6:0] room_count   = '0;
    logic       beam_a_armed = 1'b0;
    logic       beam_b_armed = 1'b0;
    logic [7:0] armed_ticks  = '0;
    logic [2:0] lamp_level_q = LAMPS_0;

    // Expected status items, oldest first, one per accepted input item.
    res_t room_status_q[$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int send_run       = 0;

    // Applies one input item to the predicted state and returns the status
    // item that the block should send for it.
    function automatic res_t advance_room(op_t op, logic [16:0] tod, logic dark);
        logic [7:0] bumped;
        logic [2:0] lv;
        res_t       status;
        case (op)
            OP_TICK:
            begin
                // Ticks only count while a beam event waits for its partner.
                if (beam_a_armed || beam_b_armed)
                begin
                    armed_ticks = armed_ticks + 8'd1;
                    if (armed_ticks >= room_cfg.timeout)
                        {beam_a_armed, beam_b_armed, armed_ticks} = '0;
                end
            end
            OP_BEAM_A:
            begin
                if (beam_b_armed)
                begin
                    // B then A: someone came in. A count above a lowered ceiling
                    // is pulled down to the ceiling here.
                    bumped = {1'b0, room_count} + 8'd1;
                    if (bumped >= {1'b0, room_cfg.max_occ})
                        bumped = {1'b0, room_cfg.max_occ};
                    room_count = bumped[6:0];
                    {beam_a_armed, beam_b_armed, armed_ticks} = '0;
                end
                else
                    beam_a_armed = 1'b1;
            end
            OP_BEAM_B:
            begin
                if (beam_a_armed)
                begin
                    // A then B: someone left; the count never goes below zero.
                    if (room_count > 0)
                        room_count = room_count - 7'd1;
                    {beam_a_armed, beam_b_armed, armed_ticks} = '0;
                end
                else
                    beam_b_armed = 1'b1;
            end
            default:
            begin
                if (tod >= room_cfg.window_start && tod <= room_cfg.window_end && dark)
                begin
                    // The tests run in a fixed order and the last one that
                    // holds wins, which matters when thresholds are unordered.
                    lv = lamp_level_q;
                    if (room_count == 0)
                        lv = LAMPS_0;
                    if (room_count > 0 && room_count < room_cfg.level_one)
                        lv = LAMPS_1;
                    if (room_count >= room_cfg.level_one && room_count < room_cfg.level_two)
                        lv = LAMPS_2;
                    if (room_count >= room_cfg.level_two && room_count < room_cfg.level_three)
                        lv = LAMPS_3;
                    if (room_count >= room_cfg.level_three)
                        lv = LAMPS_4;
                    lamp_level_q = lv;
                end
                else
                    lamp_level_q = LAMPS_0;
            end
        endcase
        status.lamps_on  = lamp_level_q;
        status.occupancy = room_count;
        status.pending   = beam_a_armed ? PEND_A : (beam_b_armed ? PEND_B : PEND_NONE);
        return status;
    endfunction

    // Number of idle cycles before the next item or after a result. Now and
    // then a run of items goes through with no idling at all.
    function automatic int pick_gap(inout int run_left);
        if (run_left > 0)
        begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            run_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    // Time of day for an item: mostly on or next to the window's edges, inside
    // the window, or anywhere in the 17-bit range, including past the day's end.
    function automatic logic [16:0] pick_tod();
        case ($urandom_range(0, 7))
            0:       return room_cfg.window_start;
            1:       return room_cfg.window_start - 17'd1;
            2:       return room_cfg.window_end;
            3:       return room_cfg.window_end + 17'd1;
            4, 5:    return 17'($urandom_range(room_cfg.window_start, room_cfg.window_end));
            default: return 17'($urandom_range(0, 131071));
        endcase
    endfunction

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch in %s at %0t: got %0d, expected %0d", field, $time, got, want);
        mismatch_count++;
    endtask

    // Offers one item on the input stream and, once it is taken, records the
    // status the block owes for it. With typed set, the typed status is
    // expected instead of the predicted one; the prediction still advances.
    // The item stays offered after the handshake: the next call either
    // replaces it at once or lowers tvalid, so no step assigns tvalid twice.
    task automatic offer_event(op_t op, logic [16:0] tod, logic dark, bit typed, res_t want);
        int   gap;
        res_t predicted;
        gap = pick_gap(send_run);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, dark, tod};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = advance_room(op, tod, dark);
        room_status_q.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Stops sending and waits until every owed status item has arrived, then
    // lets the clock run on so that the block is idle for register writes.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (room_status_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes one register and mirrors the write into the predicted registers.
    // The caller lowers cfg_we after the last write of a batch.
    task automatic program_register(reg_idx_t idx, logic [16:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_WINDOW_START: room_cfg.window_start = value;
            REG_WINDOW_END:   room_cfg.window_end   = value;
            REG_TIMEOUT:      room_cfg.timeout      = value[7:0];
            REG_LEVEL_ONE:    room_cfg.level_one    = value[6:0];
            REG_LEVEL_TWO:    room_cfg.level_two    = value[6:0];
            REG_LEVEL_THREE:  room_cfg.level_three  = value[6:0];
            default:          room_cfg.max_occ      = value[6:0];
        endcase
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Directed script. Each row is either an item or a register write.
    // Fixed rows carry the status that can be read off directly; predicted
    // rows are checked against the predictor. The script walks through the
    // window edges, dark and bright, pairs in both orders, counting down at
    // zero, repeated beam events, a time past the end of the day, and then
    // a reversed window, unordered thresholds, a zero timeout, a ceiling of
    // zero and a count above the ceiling.
    // ------------------------------------------------------------------
    typedef enum logic [1:0] {
        ROW_FIXED,
        ROW_PREDICT,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        op_t               op;
        logic [16:0]       arg;     // time of day for items, value for writes
        logic              dark;
        reg_idx_t          idx;
        logic [LAMP_W-1:0] lamps;
        logic [LVL_W-1:0]  occ;
        logic [PEND_W-1:0] pend;
    } script_row_t;

    localparam int SCRIPT_LEN = 30;
    localparam script_row_t DIRECTED_SCRIPT [SCRIPT_LEN] = '{
        '{ROW_FIXED,   OP_EVAL,   17'd70000,  1'b1, REG_WINDOW_START, LAMPS_0, 7'd0, PEND_NONE},
        '{ROW_FIXED,   OP_TICK,   17'd0,      1'b0, REG_WINDOW_START, LAMPS_0, 7'd0, PEND_NONE},
        '{ROW_FIXED,   OP_BEAM_A, 17'd0,      1'b0, REG_WINDOW_START, LAMPS_0, 7'd0, PEND_A},
        '{ROW_FIXED,   OP_BEAM_B, 17'd131071, 1'b1, REG_WINDOW_START, LAMPS_0, 7'd0, PEND_NONE},
        '{ROW_FIXED,   OP_BEAM_B, 17'd12345,  1'b0, REG_WINDOW_START, LAMPS_0, 7'd0, PEND_B},
        '{ROW_FIXED,   OP_BEAM_B, 17'd98765,  1'b1, REG_WINDOW_START, LAMPS_0, 7'd0, PEND_B},
        '{ROW_FIXED,   OP_BEAM_A, 17'd0,      1'b0, REG_WINDOW_START, LAMPS_0, 7'd1, PEND_NONE},
        '{ROW_FIXED,   OP_EVAL,   17'd64800,  1'b1, REG_WINDOW_START, LAMPS_1, 7'd1, PEND_NONE},
        '{ROW_FIXED,   OP_EVAL,   17'd79200,  1'b1, REG_WINDOW_START, LAMPS_1, 7'd1, PEND_NONE},
        '{ROW_FIXED,   OP_EVAL,   17'd79201,  1'b1, REG_WINDOW_START, LAMPS_0, 7'd1, PEND_NONE},
        '{ROW_FIXED,   OP_EVAL,   17'd70000,  1'b0, REG_WINDOW_START, LAMPS_0, 7'd1, PEND_NONE},
        '{ROW_FIXED,   OP_EVAL,   17'd70000,  1'b1, REG_WINDOW_START, LAMPS_1, 7'd1, PEND_NONE},
        '{ROW_FIXED,   OP_BEAM_A, 17'd5,      1'b0, REG_WINDOW_START, LAMPS_1, 7'd1, PEND_A},
        '{ROW_FIXED,   OP_BEAM_B, 17'd6,      1'b1, REG_WINDOW_START, LAMPS_1, 7'd0, PEND_NONE},
        '{ROW_FIXED,   OP_EVAL,   17'd131071, 1'b1, REG_WINDOW_START, LAMPS_0, 7'd0, PEND_NONE},
        '{ROW_FIXED,   OP_BEAM_B, 17'd0,      1'b0, REG_WINDOW_START, LAMPS_0, 7'd0, PEND_B},
        '{ROW_PREDICT, OP_TICK,   17'd0,      1'b0, REG_WINDOW_START, LAMPS_0, 7'd0, PEND_NONE},
        '{ROW_PREDICT, OP_BEAM_A, 17'd0,      1'b0, REG_WINDOW_START, LAMPS_0, 7'd0, PEND_NONE},
        // Reversed window: start after end, so nothing is inside it.
        '{ROW_WRITE,   OP_TICK,   17'd80000,  1'b0, REG_WINDOW_START, LAMPS_0, 7'd0, PEND_NONE},
        '{ROW_FIXED,   OP_EVAL,   17'd79200,  1'b1, REG_WINDOW_START, LAMPS_0, 7'd1, PEND_NONE},
        // Unordered thresholds: the four-lamp test comes last and wins.
        '{ROW_WRITE,   OP_TICK,   17'd0,      1'b0, REG_WINDOW_START, LAMPS_0, 7'd0, PEND_NONE},
        '{ROW_WRITE,   OP_TICK,   17'd1,      1'b0, REG_LEVEL_THREE,  LAMPS_0, 7'd0, PEND_NONE},
        '{ROW_FIXED,   OP_EVAL,   17'd0,      1'b1, REG_WINDOW_START, LAMPS_4, 7'd1, PEND_NONE},
        // A zero timeout drops a lone beam event on its first tick.
        '{ROW_WRITE,   OP_TICK,   17'd0,      1'b0, REG_TIMEOUT,      LAMPS_0, 7'd0, PEND_NONE},
        '{ROW_FIXED,   OP_BEAM_A, 17'd0,      1'b0, REG_WINDOW_START, LAMPS_4, 7'd1, PEND_A},
        '{ROW_FIXED,   OP_TICK,   17'd0,      1'b0, REG_WINDOW_START, LAMPS_4, 7'd1, PEND_NONE},
        // A ceiling of zero, with the count of one above it: an entry gives zero.
        '{ROW_WRITE,   OP_TICK,   17'd0,      1'b0, REG_MAX_OCC,      LAMPS_0, 7'd0, PEND_NONE},
        '{ROW_FIXED,   OP_BEAM_B, 17'd0,      1'b0, REG_WINDOW_START, LAMPS_4, 7'd1, PEND_B},
        '{ROW_FIXED,   OP_BEAM_A, 17'd0,      1'b0, REG_WINDOW_START, LAMPS_4, 7'd0, PEND_NONE},
        '{ROW_FIXED,   OP_EVAL,   17'd0,      1'b1, REG_WINDOW_START, LAMPS_0, 7'd0, PEND_NONE}
    };

    // ------------------------------------------------------------------
    // Random plan: one register setting per phase, the share of crossings
    // that are entries, and the number of items. The third phase climbs to
    // the 7-bit ceiling; the one after lowers the ceiling below the count.
    // Window end, timeout and the levels see their extremes across the plan.
    // ------------------------------------------------------------------
    typedef struct packed {
        cfg_t        cfg;
        logic [6:0]  enter_pct;
        logic [10:0] items;
    } phase_t;

    localparam int NUM_PHASES = 8;
    localparam phase_t RANDOM_PLAN [NUM_PHASES] = '{
        '{'{17'd64800, 17'd79200,  8'd60,  7'd10,  7'd20,  7'd30,  7'd99},  7'd75,  11'd170},
        '{'{17'd0,     17'd86399,  8'd1,   7'd5,   7'd15,  7'd25,  7'd127}, 7'd80,  11'd170},
        '{'{17'd43200, 17'd50000,  8'd8,   7'd127, 7'd127, 7'd127, 7'd127}, 7'd100, 11'd700},
        '{'{17'd0,     17'd131071, 8'd255, 7'd60,  7'd5,   7'd127, 7'd20},  7'd50,  11'd170},
        '{'{17'd0,     17'd0,      8'd3,   7'd0,   7'd0,   7'd0,   7'd1},   7'd30,  11'd170},
        '{'{17'd86399, 17'd86399,  8'd0,   7'd3,   7'd2,   7'd1,   7'd127}, 7'd60,  11'd170},
        '{'{17'd70000, 17'd10000,  8'd2,   7'd10,  7'd20,  7'd30,  7'd50},  7'd40,  11'd170},
        '{'{17'd64800, 17'd79200,  8'd60,  7'd10,  7'd20,  7'd30,  7'd99},  7'd10,  11'd170}
    };

    // ------------------------------------------------------------------
    // Result checker. A status item counts as taken at a rising edge where
    // both m_tvalid and m_tready were high; it is compared field by field
    // with the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : status_check
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = res_t'(m_tdata[11:0]);
            if (room_status_q.size() == 0)
                report_mismatch("status item with none expected", got, 0);
            else
            begin
                want = room_status_q.pop_front();
                if (got.lamps_on !== want.lamps_on)
                    report_mismatch("lamps_on", got.lamps_on, want.lamps_on);
                if (got.occupancy !== want.occupancy)
                    report_mismatch("occupancy", got.occupancy, want.occupancy);
                if (got.pending !== want.pending)
                    report_mismatch("pending", got.pending, want.pending);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver. After each taken status item it draws a stall from pick_gap;
    // at regular points it holds off for a long stretch instead, so that both
    // internal registers fill and the block stalls its input while the sender
    // keeps offering items.
    // ------------------------------------------------------------------
    initial
    begin : status_sink
        int hold_left;
        int run_left;
        int taken;
        hold_left = 0;
        run_left  = 0;
        taken     = 0;
        @(posedge rst_n);
        @(posedge clk);
        m_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                taken++;
                hold_left = (taken % HOLD_PERIOD == 300) ? HOLD_CYCLES : pick_gap(run_left);
                if (hold_left > 0)
                    m_tready <= 1'b0;
            end
            else if (!m_tready)
            begin
                hold_left--;
                if (hold_left == 0)
                    m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: a run that has not finished by the cycle limit has failed.
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus. Reset, the directed script, then the random phases. Each
    // phase starts with the sender paused until every owed status item has
    // come back, so the registers are written while the block is idle.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        script_row_t row;
        phase_t      plan;
        int          phase_end;
        int          ticks;
        int          tick_cap;
        bit          entering;
        int          pick;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            row = DIRECTED_SCRIPT[i];
            if (row.kind == ROW_WRITE)
            begin
                drain_results();
                program_register(row.idx, row.arg);
                cfg_we <= 1'b0;
            end
            else
                offer_event(row.op, row.arg, row.dark, row.kind == ROW_FIXED,
                            res_t'({row.pend, row.occ, row.lamps}));
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            plan = RANDOM_PLAN[p];
            drain_results();
            program_register(REG_WINDOW_START, plan.cfg.window_start);
            program_register(REG_WINDOW_END,   plan.cfg.window_end);
            program_register(REG_TIMEOUT,      17'(plan.cfg.timeout));
            program_register(REG_LEVEL_ONE,    17'(plan.cfg.level_one));
            program_register(REG_LEVEL_TWO,    17'(plan.cfg.level_two));
            program_register(REG_LEVEL_THREE,  17'(plan.cfg.level_three));
            program_register(REG_MAX_OCC,      17'(plan.cfg.max_occ));
            cfg_we <= 1'b0;

            // Long tick runs are kept short of the largest timeouts.
            tick_cap  = (int'(room_cfg.timeout) + 2 < 70) ? int'(room_cfg.timeout) + 2 : 70;
            phase_end = items_sent + int'(plan.items);
            while (items_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                begin
                    // A person walking through: the two beams in order, a few
                    // ticks between them (sometimes enough to time out), and
                    // often an evaluation afterwards.
                    entering = $urandom_range(0, 99) < plan.enter_pct;
                    offer_event(entering ? OP_BEAM_B : OP_BEAM_A, pick_tod(),
                                1'($urandom_range(0, 1)), 1'b0, '0);
                    ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(0, tick_cap)
                                                        : $urandom_range(0, 3);
                    repeat (ticks)
                        offer_event(OP_TICK, pick_tod(), 1'($urandom_range(0, 1)), 1'b0, '0);
                    offer_event(entering ? OP_BEAM_A : OP_BEAM_B, pick_tod(),
                                1'($urandom_range(0, 1)), 1'b0, '0);
                    if ($urandom_range(0, 2) == 0)
                        offer_event(OP_EVAL, pick_tod(), 1'($urandom_range(0, 1)), 1'b0, '0);
                end
                else if (pick < 80)
                    offer_event(OP_EVAL, pick_tod(), 1'($urandom_range(0, 1)), 1'b0, '0);
                else if (pick < 92)
                    offer_event(op_t'($urandom_range(0, 3)), pick_tod(),
                                1'($urandom_range(0, 1)), 1'b0, '0);
                else
                begin
                    // A lone beam event left to age out under a run of ticks.
                    offer_event($urandom_range(0, 1) ? OP_BEAM_A : OP_BEAM_B, pick_tod(),
                                1'($urandom_range(0, 1)), 1'b0, '0);
                    ticks = $urandom_range(0, tick_cap);
                    repeat (ticks)
                        offer_event(OP_TICK, pick_tod(), 1'($urandom_range(0, 1)), 1'b0, '0);
                end
            end
        end

        // Everything is sent: wait for the last status items, then a quiet
        // stretch in which nothing more may arrive.
        s_tvalid <= 1'b0;
        while (room_status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
